>>> hdl/mahd_pkg.sv
// Shared types, codes and lookup tables for the MPEG audio header decoder.
// No dependencies; every other file refers to this package by scoped names.
package mahd_pkg;

   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_NO_SYNC  = 3'd1;
   localparam logic [2:0] STATUS_LAYER    = 3'd2;
   localparam logic [2:0] STATUS_BITRATE  = 3'd3;
   localparam logic [2:0] STATUS_RATE     = 3'd4;
   localparam logic [2:0] STATUS_PER_CHAN = 3'd5;

   localparam logic [1:0] LAYER_RESERVED = 2'd0;
   localparam logic [1:0] LAYER_III      = 2'd1;
   localparam logic [1:0] LAYER_II       = 2'd2;
   localparam logic [1:0] LAYER_I        = 2'd3;

   localparam logic [1:0] MODE_STEREO = 2'd0;
   localparam logic [1:0] MODE_JOINT  = 2'd1;
   localparam logic [1:0] MODE_MONO   = 2'd3;

   localparam logic [1:0] VER_MPEG1 = 2'd1;
   localparam logic [1:0] VER_MPEG25 = 2'd2;

   localparam int NUM_W   = 26;
   localparam int RECIP_W = 20;
   localparam int RECIP_SHIFT = 32;
   localparam int QUOT_W  = 14;

   // Reciprocals scaled by two to the 32nd, rounded down.
   localparam logic [RECIP_W-1:0] RECIP_44100 = RECIP_W'(64'h1_0000_0000 / 44100);
   localparam logic [RECIP_W-1:0] RECIP_48000 = RECIP_W'(64'h1_0000_0000 / 48000);
   localparam logic [RECIP_W-1:0] RECIP_32000 = RECIP_W'(64'h1_0000_0000 / 32000);
   localparam logic [RECIP_W-1:0] RECIP_22050 = RECIP_W'(64'h1_0000_0000 / 22050);
   localparam logic [RECIP_W-1:0] RECIP_24000 = RECIP_W'(64'h1_0000_0000 / 24000);
   localparam logic [RECIP_W-1:0] RECIP_16000 = RECIP_W'(64'h1_0000_0000 / 16000);
   localparam logic [RECIP_W-1:0] RECIP_11025 = RECIP_W'(64'h1_0000_0000 / 11025);
   localparam logic [RECIP_W-1:0] RECIP_12000 = RECIP_W'(64'h1_0000_0000 / 12000);
   localparam logic [RECIP_W-1:0] RECIP_8000  = RECIP_W'(64'h1_0000_0000 / 8000);

   localparam logic [15:0] RATE_TAB [0:2][0:3] = '{
      '{16'd22050, 16'd24000, 16'd16000, 16'd0},
      '{16'd44100, 16'd48000, 16'd32000, 16'd0},
      '{16'd11025, 16'd12000, 16'd8000,  16'd0}
   };

   localparam logic [18:0] KBPS_TAB [0:2][0:2][0:15] = '{
      '{
         '{19'd0, 19'd8000, 19'd16000, 19'd24000, 19'd32000, 19'd40000, 19'd48000,
           19'd56000, 19'd64000, 19'd80000, 19'd96000, 19'd112000, 19'd128000,
           19'd144000, 19'd160000, 19'd0},
         '{19'd0, 19'd8000, 19'd16000, 19'd24000, 19'd32000, 19'd40000, 19'd48000,
           19'd56000, 19'd64000, 19'd80000, 19'd96000, 19'd112000, 19'd128000,
           19'd144000, 19'd160000, 19'd0},
         '{19'd0, 19'd32000, 19'd48000, 19'd56000, 19'd64000, 19'd80000, 19'd96000,
           19'd112000, 19'd128000, 19'd144000, 19'd160000, 19'd176000, 19'd192000,
           19'd224000, 19'd256000, 19'd0}
      },
      '{
         '{19'd0, 19'd32000, 19'd40000, 19'd48000, 19'd56000, 19'd64000, 19'd80000,
           19'd96000, 19'd112000, 19'd128000, 19'd160000, 19'd192000, 19'd224000,
           19'd256000, 19'd320000, 19'd0},
         '{19'd0, 19'd32000, 19'd48000, 19'd56000, 19'd64000, 19'd80000, 19'd96000,
           19'd112000, 19'd128000, 19'd160000, 19'd192000, 19'd224000, 19'd256000,
           19'd320000, 19'd384000, 19'd0},
         '{19'd0, 19'd32000, 19'd64000, 19'd96000, 19'd128000, 19'd160000, 19'd192000,
           19'd224000, 19'd256000, 19'd288000, 19'd320000, 19'd352000, 19'd384000,
           19'd416000, 19'd448000, 19'd0}
      },
      '{
         '{19'd0, 19'd6000, 19'd8000, 19'd10000, 19'd12000, 19'd16000, 19'd20000,
           19'd24000, 19'd28000, 19'd32000, 19'd40000, 19'd48000, 19'd56000,
           19'd64000, 19'd80000, 19'd0},
         '{19'd0, 19'd6000, 19'd8000, 19'd10000, 19'd12000, 19'd16000, 19'd20000,
           19'd24000, 19'd28000, 19'd32000, 19'd40000, 19'd48000, 19'd56000,
           19'd64000, 19'd80000, 19'd0},
         '{19'd0, 19'd8000, 19'd12000, 19'd16000, 19'd20000, 19'd24000, 19'd32000,
           19'd40000, 19'd48000, 19'd56000, 19'd64000, 19'd80000, 19'd96000,
           19'd112000, 19'd128000, 19'd0}
      }
   };

   typedef struct packed {
      logic [2:0]         status;
      logic [1:0]         version_index;
      logic [1:0]         layer_code;
      logic               crc_present;
      logic [18:0]        bit_rate;
      logic [15:0]        sample_rate;
      logic               padding;
      logic [1:0]         channel_mode;
      logic [1:0]         mode_extension;
      logic [5:0]         subband_bound;
      logic [13:0]        frame_duration;
      logic [NUM_W-1:0]   numerator;
      logic [RECIP_W-1:0] recip;
   } front_item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [1:0]  version_index;
      logic [1:0]  layer_code;
      logic        crc_present;
      logic [18:0] bit_rate;
      logic [15:0] sample_rate;
      logic        padding;
      logic [1:0]  channel_mode;
      logic [1:0]  mode_extension;
      logic [5:0]  subband_bound;
      logic [13:0] frame_duration;
      logic [11:0] frame_bytes;
   } result_type;

   function automatic logic [RECIP_W-1:0] recip_of(input logic [15:0] fs);
      logic [RECIP_W-1:0] r;
      case (fs)
         16'd44100: r = RECIP_44100;
         16'd48000: r = RECIP_48000;
         16'd32000: r = RECIP_32000;
         16'd22050: r = RECIP_22050;
         16'd24000: r = RECIP_24000;
         16'd16000: r = RECIP_16000;
         16'd11025: r = RECIP_11025;
         16'd12000: r = RECIP_12000;
         16'd8000:  r = RECIP_8000;
         default:   r = '0;
      endcase
      return r;
   endfunction

   // Frame duration: the long constant for Layers II and III, the short one for Layer I.
   function automatic logic [13:0] duration_of(input logic layer_one, input logic [15:0] fs);
      logic [13:0] d;
      case (fs)
         16'd44100: d = layer_one ? 14'd783  : 14'd2351;
         16'd48000: d = layer_one ? 14'd720  : 14'd2160;
         16'd32000: d = layer_one ? 14'd1080 : 14'd3240;
         16'd22050: d = layer_one ? 14'd1567 : 14'd4702;
         16'd24000: d = layer_one ? 14'd1440 : 14'd4320;
         16'd16000: d = layer_one ? 14'd2160 : 14'd6480;
         16'd11025: d = layer_one ? 14'd3134 : 14'd9404;
         16'd12000: d = layer_one ? 14'd2880 : 14'd8640;
         16'd8000:  d = layer_one ? 14'd4320 : 14'd12960;
         default:   d = '0;
      endcase
      return d;
   endfunction

endpackage

>>> hdl/mpeg_audio_header_decoder.sv
// MPEG audio frame header decoder: one header word in, one result word out.
// A result passes through the input queue, the multiply stage and the result queue before it is ready.
// Throughput: one header per cycle while results are popped, made possible by the registered reciprocal multiply.
// Reset (synchronous, active high) empties both queues and clears the multiply stage's valid flag.
// Depends on mahd_pkg, mahd_front, mahd_queue and mahd_back.
module mpeg_audio_header_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [31:0] req_header_word,
   output logic        empty,
   input  logic        pop,
   output logic [2:0]  rsp_status,
   output logic [1:0]  rsp_version_index,
   output logic [1:0]  rsp_layer_code,
   output logic        rsp_crc_present,
   output logic [18:0] rsp_bit_rate,
   output logic [15:0] rsp_sample_rate,
   output logic        rsp_padding,
   output logic [1:0]  rsp_channel_mode,
   output logic [1:0]  rsp_mode_extension,
   output logic [5:0]  rsp_subband_bound,
   output logic [13:0] rsp_frame_duration,
   output logic [11:0] rsp_frame_bytes
);

   mahd_pkg::front_item_type front_item;
   mahd_pkg::front_item_type queue_item;
   mahd_pkg::result_type     rsp;
   logic                     queue_valid;
   logic                     queue_pop;

   mahd_front u_front (
      .header_word (req_header_word),
      .item        (front_item)
   );

   mahd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .full      (full),
      .pop       (queue_pop),
      .valid     (queue_valid),
      .pop_item  (queue_item)
   );

   mahd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (queue_valid),
      .in_item  (queue_item),
      .in_pop   (queue_pop),
      .pop      (pop),
      .empty    (empty),
      .rsp      (rsp)
   );

   assign rsp_status         = rsp.status;
   assign rsp_version_index  = rsp.version_index;
   assign rsp_layer_code     = rsp.layer_code;
   assign rsp_crc_present    = rsp.crc_present;
   assign rsp_bit_rate       = rsp.bit_rate;
   assign rsp_sample_rate    = rsp.sample_rate;
   assign rsp_padding        = rsp.padding;
   assign rsp_channel_mode   = rsp.channel_mode;
   assign rsp_mode_extension = rsp.mode_extension;
   assign rsp_subband_bound  = rsp.subband_bound;
   assign rsp_frame_duration = rsp.frame_duration;
   assign rsp_frame_bytes    = rsp.frame_bytes;

endmodule

>>> hdl/mahd_front.sv
// Front end: decodes and checks one header word and prepares the division.
// Depends on mahd_pkg.
module mahd_front (
   input  logic [31:0]              header_word,
   output mahd_pkg::front_item_type item
);

   logic [1:0]  ver;
   logic [1:0]  layer;
   logic [18:0] br;
   logic [15:0] fs;
   logic [18:0] br_chan;
   logic [1:0]  mext;
   logic [5:0]  bound;
   logic [5:0]  limit;
   logic        l2_mpeg1;
   logic [2:0]  status;

   always_comb begin
      ver = {1'b0, header_word[19]};
      if (header_word[19] && header_word[1:0] == 2'd2) begin
         ver = mahd_pkg::VER_MPEG25;
      end
      layer = header_word[18:17];
      br = (layer == mahd_pkg::LAYER_RESERVED) ? 19'd0 :
           mahd_pkg::KBPS_TAB[ver][2'(layer - 2'd1)][header_word[15:12]];
      fs = mahd_pkg::RATE_TAB[ver][header_word[11:10]];
      mext = (header_word[7:6] == mahd_pkg::MODE_STEREO) ? 2'd0 : header_word[5:4];
      bound = (header_word[7:6] == mahd_pkg::MODE_JOINT) ?
              {1'b0, {1'b0, mext} + 3'd1, 2'b00} : 6'd32;
      br_chan = (header_word[7:6] == mahd_pkg::MODE_MONO) ? br : {1'b0, br[18:1]};
      l2_mpeg1 = (ver == mahd_pkg::VER_MPEG1) && (layer == mahd_pkg::LAYER_II);

      limit = 6'd32;
      if (l2_mpeg1) begin
         if (br < 19'd56000) begin
            limit = (fs == 16'd32000) ? 6'd12 : 6'd8;
         end else if (br < 19'd96000) begin
            limit = 6'd27;
         end else begin
            limit = (fs == 16'd48000) ? 6'd27 : 6'd30;
         end
      end else if (layer == mahd_pkg::LAYER_II) begin
         limit = 6'd30;
      end
      if (layer != mahd_pkg::LAYER_I && bound > limit) begin
         bound = limit;
      end

      if (header_word[31:20] != 12'hFFF) begin
         status = mahd_pkg::STATUS_NO_SYNC;
      end else if (layer == mahd_pkg::LAYER_RESERVED) begin
         status = mahd_pkg::STATUS_LAYER;
      end else if (br == 19'd0) begin
         status = mahd_pkg::STATUS_BITRATE;
      end else if (fs == 16'd0) begin
         status = mahd_pkg::STATUS_RATE;
      end else if (l2_mpeg1 && (br_chan < 19'd32000 || br_chan > 19'd192000)) begin
         status = mahd_pkg::STATUS_PER_CHAN;
      end else begin
         status = mahd_pkg::STATUS_OK;
      end

      item = '0;
      item.status = status;
      if (status == mahd_pkg::STATUS_OK) begin
         item.version_index  = ver;
         item.layer_code     = layer;
         item.crc_present    = ~header_word[16];
         item.bit_rate       = br;
         item.sample_rate    = fs;
         item.padding        = header_word[9];
         item.channel_mode   = header_word[7:6];
         item.mode_extension = mext;
         item.subband_bound  = bound;
         item.frame_duration = mahd_pkg::duration_of(layer == mahd_pkg::LAYER_I, fs);
         item.numerator = (layer == mahd_pkg::LAYER_I) ?
                          mahd_pkg::NUM_W'(br * 5'd12) : mahd_pkg::NUM_W'(br * 8'd144);
         item.recip = mahd_pkg::recip_of(fs);
      end
   end

endmodule

>>> hdl/mahd_queue.sv
// Two-word queue between the front end and the division back end.
// Depends on mahd_pkg.
module mahd_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  mahd_pkg::front_item_type push_item,
   output logic                     full,
   input  logic                     pop,
   output logic                     valid,
   output mahd_pkg::front_item_type pop_item
);

   mahd_pkg::front_item_type mem_ff [0:1];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign valid    = (count_ff != 2'd0);
   assign pop_item = mem_ff[rptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      wptr_in  = do_push ? ~wptr_ff : wptr_ff;
      rptr_in  = do_pop ? ~rptr_ff : rptr_ff;
      count_in = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         mem_ff[wptr_ff] <= push_item;
      end
   end

endmodule

>>> hdl/mahd_back.sv
// Back end: reciprocal division for the frame size and the result queue.
// Depends on mahd_pkg.
module mahd_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  mahd_pkg::front_item_type in_item,
   output logic                     in_pop,
   input  logic                     pop,
   output logic                     empty,
   output mahd_pkg::result_type     rsp
);

   localparam int PROD_W = mahd_pkg::NUM_W + mahd_pkg::RECIP_W;

   mahd_pkg::front_item_type s1_item_ff;
   logic [PROD_W-1:0]        s1_prod_ff;
   logic                     s1_valid_ff;

   mahd_pkg::result_type     mem_ff [0:3];
   logic [1:0]               wptr_ff, rptr_ff;
   logic [2:0]               count_ff, count_in;
   logic                     do_pop;

   logic [mahd_pkg::QUOT_W-1:0] q0;
   logic [mahd_pkg::QUOT_W-1:0] q;
   logic [29:0]                 q_fs;
   logic [mahd_pkg::NUM_W-1:0]  rem;
   logic [11:0]                 bytes;
   mahd_pkg::result_type        res;

   // A word is only issued when the result queue can surely take it, so the
   // pipeline never has to stall.
   assign in_pop = in_valid && (count_ff + 3'(s1_valid_ff) < 3'd4);
   assign empty  = (count_ff == 3'd0);
   assign rsp    = mem_ff[rptr_ff];
   assign do_pop = pop && !empty;

   always_comb begin
      // The reciprocal estimate is at most one below the true quotient.
      q0   = s1_prod_ff[mahd_pkg::RECIP_SHIFT +: mahd_pkg::QUOT_W];
      q_fs = q0 * s1_item_ff.sample_rate;
      rem  = s1_item_ff.numerator - q_fs[mahd_pkg::NUM_W-1:0];
      q    = (rem >= {10'd0, s1_item_ff.sample_rate}) ? q0 + 1'b1 : q0;
      if (s1_item_ff.layer_code == mahd_pkg::LAYER_I) begin
         bytes = {q[9:0], 2'b00} + {9'd0, s1_item_ff.padding, 2'b00};
      end else begin
         bytes = q[11:0] + {11'd0, s1_item_ff.padding};
      end
      res.status         = s1_item_ff.status;
      res.version_index  = s1_item_ff.version_index;
      res.layer_code     = s1_item_ff.layer_code;
      res.crc_present    = s1_item_ff.crc_present;
      res.bit_rate       = s1_item_ff.bit_rate;
      res.sample_rate    = s1_item_ff.sample_rate;
      res.padding        = s1_item_ff.padding;
      res.channel_mode   = s1_item_ff.channel_mode;
      res.mode_extension = s1_item_ff.mode_extension;
      res.subband_bound  = s1_item_ff.subband_bound;
      res.frame_duration = s1_item_ff.frame_duration;
      res.frame_bytes    = (s1_item_ff.status == mahd_pkg::STATUS_OK) ? bytes : 12'd0;
      count_in = count_ff + 3'(s1_valid_ff) - 3'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         wptr_ff     <= 2'd0;
         rptr_ff     <= 2'd0;
         count_ff    <= 3'd0;
      end else begin
         s1_valid_ff <= in_pop;
         wptr_ff     <= wptr_ff + 2'(s1_valid_ff);
         rptr_ff     <= rptr_ff + 2'(do_pop);
         count_ff    <= count_in;
      end
      s1_item_ff <= in_item;
      s1_prod_ff <= in_item.numerator * in_item.recip;
      if (s1_valid_ff) begin
         mem_ff[wptr_ff] <= res;
      end
   end

endmodule

>>> tb/tb_mpeg_audio_header_decoder.sv
// Self-checking testbench for the MPEG audio header decoder.
// Depends on mahd_pkg and mpeg_audio_header_decoder; predicts each result word in place.
`timescale 1ns / 1ps

module tb_mpeg_audio_header_decoder;

   localparam int WATCHDOG_LIMIT = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        pop = 1'b0;
   logic [31:0] req_header_word = '0;
   logic        full, empty;
   mahd_pkg::result_type actual;

   mpeg_audio_header_decoder dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_header_word(req_header_word), .empty(empty), .pop(pop),
      .rsp_status(actual.status), .rsp_version_index(actual.version_index),
      .rsp_layer_code(actual.layer_code), .rsp_crc_present(actual.crc_present),
      .rsp_bit_rate(actual.bit_rate), .rsp_sample_rate(actual.sample_rate),
      .rsp_padding(actual.padding), .rsp_channel_mode(actual.channel_mode),
      .rsp_mode_extension(actual.mode_extension),
      .rsp_subband_bound(actual.subband_bound),
      .rsp_frame_duration(actual.frame_duration),
      .rsp_frame_bytes(actual.frame_bytes)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [31:0] pending_headers[$];
   mahd_pkg::result_type expected_results[$];
   int          mismatches = 0;
   int          idle_cycles = 0;
   bit          stimulus_done = 1'b0;

   function automatic mahd_pkg::result_type decode_header(input logic [31:0] w);
      mahd_pkg::result_type r;
      logic [1:0]  ver, layer, mode, mext;
      logic [18:0] br;
      logic [15:0] fs;
      logic [5:0]  bound, cap;
      logic [31:0] per_chan;
      r = '0;
      if (w[31:20] != 12'hFFF) begin
         r.status = mahd_pkg::STATUS_NO_SYNC;
         return r;
      end
      ver = {1'b0, w[19]};
      if (w[19] && w[1:0] == 2'd2) ver = mahd_pkg::VER_MPEG25;
      layer = w[18:17];
      if (layer == mahd_pkg::LAYER_RESERVED) begin
         r.status = mahd_pkg::STATUS_LAYER;
         return r;
      end
      br = mahd_pkg::KBPS_TAB[ver][layer - 1][w[15:12]];
      if (br == 0) begin
         r.status = mahd_pkg::STATUS_BITRATE;
         return r;
      end
      fs = mahd_pkg::RATE_TAB[ver][w[11:10]];
      if (fs == 0) begin
         r.status = mahd_pkg::STATUS_RATE;
         return r;
      end
      mode = w[7:6];
      mext = (mode == mahd_pkg::MODE_STEREO) ? 2'd0 : w[5:4];
      bound = (mode == mahd_pkg::MODE_JOINT) ? 6'((mext + 1) * 4) : 6'd32;
      cap = 6'd32;
      if (ver == mahd_pkg::VER_MPEG1 && layer == mahd_pkg::LAYER_II) begin
         per_chan = (mode == mahd_pkg::MODE_MONO) ? br : br / 2;
         if (per_chan < 32000 || per_chan > 192000) begin
            r.status = mahd_pkg::STATUS_PER_CHAN;
            return r;
         end
         if (br < 56000) cap = (fs == 32000) ? 6'd12 : 6'd8;
         else if (br < 96000) cap = 6'd27;
         else cap = (fs == 48000) ? 6'd27 : 6'd30;
      end else if (layer == mahd_pkg::LAYER_II) begin
         cap = 6'd30;
      end
      r.status = mahd_pkg::STATUS_OK;
      r.version_index = ver;
      r.layer_code = layer;
      r.crc_present = ~w[16];
      r.bit_rate = br;
      r.sample_rate = fs;
      r.padding = w[9];
      r.channel_mode = mode;
      r.mode_extension = mext;
      r.frame_duration =
         14'(((layer == mahd_pkg::LAYER_I) ? 64'd34560000 : 64'd103680000) / fs);
      if (layer != mahd_pkg::LAYER_I) begin
         r.subband_bound = (bound > cap) ? cap : bound;
         r.frame_bytes = 12'(64'd144 * br / fs + w[9]);
      end else begin
         r.subband_bound = bound;
         r.frame_bytes = 12'((64'd12 * br / fs) * 4 + 4 * w[9]);
      end
      return r;
   endfunction

   // Mostly well-formed headers with random content, some noise.
   function automatic logic [31:0] random_header();
      logic [31:0] w;
      w = $urandom;
      if ($urandom_range(0, 9) != 0) w[31:20] = 12'hFFF;
      if ($urandom_range(0, 9) < 8) begin
         if (w[18:17] == mahd_pkg::LAYER_RESERVED) w[18:17] = 2'($urandom_range(1, 3));
         if (w[15:12] == 4'd0 || w[15:12] == 4'd15) w[15:12] = 4'($urandom_range(1, 14));
         if (w[11:10] == 2'd3) w[11:10] = 2'($urandom_range(0, 2));
      end
      return w;
   endfunction

   initial begin
      logic [31:0] w;
      pending_headers.push_back(32'h0000_0000);
      pending_headers.push_back(32'hFFFF_FFFF);
      pending_headers.push_back(32'hFFEF_FFFF);   // sync broken in the low nibble
      pending_headers.push_back(32'hFFF9_9000);   // reserved layer
      pending_headers.push_back(32'hFFFD_0000);   // free-format bitrate
      pending_headers.push_back(32'hFFFD_F000);   // forbidden bitrate
      pending_headers.push_back(32'hFFFD_9C00);   // reserved sample rate
      pending_headers.push_back(32'hFFFD_10C0);   // MPEG-1 Layer II, 32k mono
      pending_headers.push_back(32'hFFFD_1000);   // per-channel rate too low
      pending_headers.push_back(32'hFFFD_E000);   // 384k stereo
      pending_headers.push_back(32'hFFFD_E0C0);   // 384k mono, too high
      pending_headers.push_back(32'hFFFD_38C0);   // 56k at 32 kHz mono
      pending_headers.push_back(32'hFFFD_5400);   // 80k stereo, 48 kHz
      pending_headers.push_back(32'hFFFD_A470);   // 192k joint at 48 kHz
      pending_headers.push_back(32'hFFFD_A070);   // 192k joint at 44.1 kHz
      pending_headers.push_back(32'hFFFB_E272);   // Layer III, low-rate tables, padded
      pending_headers.push_back(32'hFFFF_E2F2);   // Layer I, low-rate tables, padded
      pending_headers.push_back(32'hFFF3_E870);   // MPEG-2 Layer III
      pending_headers.push_back(32'hFFF5_1450);   // MPEG-2 Layer II joint
      pending_headers.push_back(32'hFFF7_E2B0);   // MPEG-2 Layer I dual
      pending_headers.push_back(32'hFFFF_E200);   // MPEG-1 Layer I, 448k padded
      for (int i = 0; i < 1500; i++) begin
         w = random_header();
         pending_headers.push_back(w);
      end
      stimulus_done = 1'b1;
   end

   int send_wait = 0;
   int take_wait = 0;

   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            expected_results.push_back(decode_header(req_header_word));
            void'(pending_headers.pop_front());
            send_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
         end
         if ((!push || !full) && send_wait > 0) begin
            send_wait--;
            push <= 1'b0;
         end else if (push && full) begin
            // hold the current word until it is taken
         end else if (pending_headers.size() > 0) begin
            push <= 1'b1;
            req_header_word <= pending_headers[0];
         end else begin
            push <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      mahd_pkg::result_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result word %h", actual);
            end else begin
               want = expected_results.pop_front();
               if (actual !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p actual %p", want, actual);
               end
            end
            take_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
         end
         if (take_wait > 0) begin
            take_wait--;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL mpeg_audio_header_decoder");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      wait (stimulus_done && pending_headers.size() == 0);
      wait (expected_results.size() == 0);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("PASS mpeg_audio_header_decoder");
      end else begin
         $display("FAIL mpeg_audio_header_decoder");
      end
      $finish;
   end

endmodule
